@@ sv/obpm_pkg.sv @@
// ---------------------------------------------------------------------------
// obpm_pkg
// shared types and constants of the order book pair matcher
// ---------------------------------------------------------------------------
package obpm_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int ID_W        = 7;
  localparam int PRICE_W     = 32;

  localparam logic SIDE_BUY = 1'b0;
  localparam logic FUNC_SUBMIT = 1'b0;
  localparam logic FUNC_MATCH  = 1'b1;

  typedef enum logic [1:0] {
    KIND_ACCEPT = 2'd0,
    KIND_REJECT = 2'd1,
    KIND_FILL   = 2'd2,
    KIND_DONE   = 2'd3
  } kind_t;

  typedef struct packed {
    logic               func;
    logic               side;
    logic [PRICE_W-1:0] price;
  } in_t;

  typedef struct packed {
    kind_t              kind;
    logic [ID_W-1:0]    order_id;
    logic [ID_W-1:0]    partner_id;
    logic [PRICE_W-1:0] fill_price;
    logic               last;
  } out_t;

  // one table entry as stored in the memory
  typedef struct packed {
    logic               side;
    logic               filled;
    logic [PRICE_W-1:0] price;
  } entry_t;

  typedef struct packed {
    logic submit;     // store order, answer accept or reject
    logic clr_i;      // start of a match pass
    logic rd_i;       // read entry i
    logic load_cur;   // capture entry i from the read data
    logic inc_i;      // move to the next entry
    logic init_j;     // start partner scan after i
    logic scan;       // issue partner read and test the previous one
    logic wr_cur;     // mark entry i filled
    logic wr_part;    // mark partner filled
    logic emit_done;  // give the pass done result
  } cmd_t;

  typedef struct packed {
    logic i_end;
    logic j_end;
    logic cur_filled;
    logic hit;
  } stat_t;

endpackage

@@ sv/order_book_pair_matcher.sv @@
// ---------------------------------------------------------------------------
// order_book_pair_matcher
// table of buy and sell orders with a sequential pair matching pass
// ---------------------------------------------------------------------------
//
//  channel   ports                    transfer happens when
//  --------  -----------------------  -------------------------------
//  input     start, busy, in_data     start high and busy low
//  result    out_valid, out_data      out_valid high (one cycle each)
//
//  a submit keeps busy low, and its result shows the next cycle
//  a match pass walks the table with one memory read port: for each pending
//  order i it reads and loads the entry, then scans the partners after i;
//  each fill then writes entry i and the partner as filled
//  reset clears the order count, the sequencer and the result strobe
//  the receiver cannot stall: every result is taken in its strobe cycle
//
module order_book_pair_matcher import obpm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data
);

  cmd_t  cmd;
  stat_t stat;

  // sequencer: idle, read entry, load entry, partner scan, two fill writes
  obpm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .func  (in_data.func),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // order memory, scan counters, price compare and result register
  obpm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

@@ sv/obpm_ctrl.sv @@
// ---------------------------------------------------------------------------
// obpm_ctrl
// sequencer of submit and match passes
// ---------------------------------------------------------------------------
module obpm_ctrl import obpm_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  logic  func,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RDI   = 6'b000010,
    S_LDI   = 6'b000100,
    S_SCAN  = 6'b001000,
    S_FILLI = 6'b010000,
    S_FILLJ = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (func == FUNC_SUBMIT) begin
            cmd.submit = 1'b1;
          end else begin
            cmd.clr_i = 1'b1;
            state_nxt = S_RDI;
          end
        end
      end
      S_RDI: begin
        if (stat.i_end) begin
          cmd.emit_done = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cmd.rd_i  = 1'b1;
          state_nxt = S_LDI;
        end
      end
      S_LDI: begin
        cmd.load_cur = 1'b1;
        if (stat.cur_filled) begin
          cmd.inc_i = 1'b1;
          state_nxt = S_RDI;
        end else begin
          cmd.init_j = 1'b1;
          state_nxt  = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.hit) begin
          state_nxt = S_FILLI;
        end else if (stat.j_end) begin
          cmd.inc_i = 1'b1;
          state_nxt = S_RDI;
        end
      end
      S_FILLI: begin
        cmd.wr_cur = 1'b1;
        state_nxt  = S_FILLJ;
      end
      S_FILLJ: begin
        cmd.wr_part = 1'b1;
        cmd.inc_i   = 1'b1;
        state_nxt   = S_RDI;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

@@ sv/obpm_dp.sv @@
// ---------------------------------------------------------------------------
// obpm_dp
// order table memory, scan counters, price compare and result register
// ---------------------------------------------------------------------------
module obpm_dp import obpm_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  in_t   in_data,
  input  cmd_t  cmd,
  output stat_t stat,
  output logic  out_valid,
  output out_t  out_data
);

  entry_t mem [TABLE_DEPTH];

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;
  logic [CNT_W-1:0] j_r, j_nxt;
  logic [CNT_W-1:0] jd_r;
  logic [CNT_W-1:0] part_r;
  logic             pv_r, pv_nxt;
  entry_t           rd_word_r;
  entry_t           cur_r;
  entry_t           part_word_r;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_word;
  logic             full;
  logic             crossed;
  logic             hit;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_r, out_nxt;

  assign full = (count_r == CNT_W'(TABLE_DEPTH));

  // partner test on the word read in the previous scan cycle
  always_comb begin
    if (cur_r.side == SIDE_BUY) begin
      crossed = (cur_r.price >= rd_word_r.price);
    end else begin
      crossed = (rd_word_r.price >= cur_r.price);
    end
  end

  assign hit = pv_r && !rd_word_r.filled && (rd_word_r.side != cur_r.side) && crossed;

  assign stat.i_end      = (i_r >= count_r);
  assign stat.j_end      = (j_r >= count_r);
  assign stat.cur_filled = rd_word_r.filled;
  assign stat.hit        = hit;

  assign rd_addr = cmd.rd_i ? i_r[IDX_W-1:0] : j_r[IDX_W-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count_r[IDX_W-1:0];
    wr_word = '{side: in_data.side, filled: 1'b0, price: in_data.price};
    if (cmd.submit) begin
      wr_en = !full;
    end else if (cmd.wr_cur) begin
      wr_en   = 1'b1;
      wr_addr = i_r[IDX_W-1:0];
      wr_word = cur_r;
      wr_word.filled = 1'b1;
    end else if (cmd.wr_part) begin
      wr_en   = 1'b1;
      wr_addr = part_r[IDX_W-1:0];
      wr_word = part_word_r;
      wr_word.filled = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_word;
    end
    rd_word_r <= mem[rd_addr];
  end

  always_comb begin
    count_nxt = count_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    pv_nxt    = 1'b0;
    if (cmd.submit && !full) begin
      count_nxt = count_r + CNT_W'(1);
    end
    if (cmd.clr_i) begin
      i_nxt = '0;
    end else if (cmd.inc_i) begin
      i_nxt = i_r + CNT_W'(1);
    end
    if (cmd.init_j) begin
      j_nxt = i_r + CNT_W'(1);
    end else if (cmd.scan && !stat.j_end) begin
      j_nxt  = j_r + CNT_W'(1);
      pv_nxt = 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    if (cmd.submit) begin
      out_valid_nxt      = 1'b1;
      out_nxt.partner_id = '0;
      out_nxt.fill_price = '0;
      out_nxt.last       = 1'b1;
      if (full) begin
        out_nxt.kind     = KIND_REJECT;
        out_nxt.order_id = '0;
      end else begin
        out_nxt.kind     = KIND_ACCEPT;
        out_nxt.order_id = ID_W'(count_r + CNT_W'(1));
      end
    end else if (cmd.scan && hit) begin
      out_valid_nxt      = 1'b1;
      out_nxt.kind       = KIND_FILL;
      out_nxt.order_id   = ID_W'(i_r + CNT_W'(1));
      out_nxt.partner_id = ID_W'(jd_r + CNT_W'(1));
      out_nxt.fill_price = rd_word_r.price;
      out_nxt.last       = 1'b0;
    end else if (cmd.emit_done) begin
      out_valid_nxt      = 1'b1;
      out_nxt.kind       = KIND_DONE;
      out_nxt.order_id   = '0;
      out_nxt.partner_id = '0;
      out_nxt.fill_price = '0;
      out_nxt.last       = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      i_r         <= '0;
      j_r         <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      pv_r        <= pv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    jd_r  <= j_r;
    if (cmd.load_cur) begin
      cur_r <= rd_word_r;
    end
    if (cmd.scan && hit) begin
      part_r      <= jd_r;
      part_word_r <= rd_word_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
